// ===== src/lcgf_pkg.sv =====
// Package for the four-constant 64-bit LCG: modes, microcode word, control store, constants.
`timescale 1ns / 1ps
package lcgf_pkg;

  localparam int unsigned PcW = 5;

  typedef enum logic [2:0] {
    MODE_SEED      = 3'd0,
    MODE_STIR      = 3'd1,
    MODE_DRAW32    = 3'd2,
    MODE_BOUNDED   = 3'd3,
    MODE_DRAW64    = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_LO,
    MUL_HI,
    MUL_BND
  } mul_op_e;

  typedef enum logic [1:0] {
    ST_NONE,
    ST_STEP,
    ST_SEED,
    ST_STIR
  } st_op_e;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_ZERO,
    RES_SET_HI,
    RES_SET_LO,
    RES_BND
  } res_op_e;

  typedef struct packed {
    mul_op_e        mul;
    st_op_e         st;
    res_op_e        res;
    logic           jmp_clr;
    logic [PcW-1:0] target;
    logic           last;
  } ucode_t;

  typedef struct packed {
    logic    en;
    mul_op_e mul;
    st_op_e  st;
    res_op_e res;
  } dp_ctrl_t;

  localparam logic [PcW-1:0] EntrySeed     = 5'd0;
  localparam logic [PcW-1:0] EntryDraw32   = 5'd1;
  localparam logic [PcW-1:0] EntryBounded  = 5'd5;
  localparam logic [PcW-1:0] EntryDraw64   = 5'd10;
  localparam logic [PcW-1:0] EntryStir     = 5'd17;
  localparam logic [PcW-1:0] StirMain      = 5'd21;
  localparam logic [PcW-1:0] EntryUnused   = 5'd24;

  function automatic logic [31:0] lcg_mult(input logic [1:0] sel);
    logic [31:0] m;
    case (sel)
      2'd0:    m = 32'd1812433253;
      2'd1:    m = 32'd2094358901;
      2'd2:    m = 32'd1809384569;
      default: m = 32'd1740025465;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] lcg_add(input logic [1:0] sel);
    logic [31:0] a;
    case (sel)
      2'd0:    a = 32'd123456789;
      2'd1:    a = 32'd239048723;
      2'd2:    a = 32'd958178125;
      default: a = 32'd281010345;
    endcase
    return a;
  endfunction

  function automatic logic [PcW-1:0] mode_entry(input logic [2:0] mode);
    logic [PcW-1:0] e;
    case (mode)
      MODE_SEED:      e = EntrySeed;
      MODE_STIR:      e = EntryStir;
      MODE_DRAW32:    e = EntryDraw32;
      MODE_BOUNDED:   e = EntryBounded;
      MODE_DRAW64:    e = EntryDraw64;
      default:        e = EntryUnused;
    endcase
    return e;
  endfunction

  function automatic ucode_t uc(input mul_op_e m, input st_op_e s, input res_op_e r,
                                input logic last);
    ucode_t w;
    w.mul     = m;
    w.st      = s;
    w.res     = r;
    w.jmp_clr = 1'b0;
    w.target  = '0;
    w.last    = last;
    return w;
  endfunction

  // control store; a generator step is MUL_LO, MUL_HI, ST_STEP
  function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
    ucode_t w;
    case (pc)
      5'd0:  w = uc(MUL_NONE, ST_SEED, RES_ZERO,   1'b1);
      5'd1:  w = uc(MUL_LO,   ST_NONE, RES_ZERO,   1'b0);
      5'd2:  w = uc(MUL_HI,   ST_NONE, RES_NONE,   1'b0);
      5'd3:  w = uc(MUL_NONE, ST_STEP, RES_NONE,   1'b0);
      5'd4:  w = uc(MUL_NONE, ST_NONE, RES_SET_LO, 1'b1);
      5'd5:  w = uc(MUL_LO,   ST_NONE, RES_ZERO,   1'b0);
      5'd6:  w = uc(MUL_HI,   ST_NONE, RES_NONE,   1'b0);
      5'd7:  w = uc(MUL_NONE, ST_STEP, RES_NONE,   1'b0);
      5'd8:  w = uc(MUL_BND,  ST_NONE, RES_NONE,   1'b0);
      5'd9:  w = uc(MUL_NONE, ST_NONE, RES_BND,    1'b1);
      5'd10: w = uc(MUL_LO,   ST_NONE, RES_ZERO,   1'b0);
      5'd11: w = uc(MUL_HI,   ST_NONE, RES_NONE,   1'b0);
      5'd12: w = uc(MUL_NONE, ST_STEP, RES_NONE,   1'b0);
      5'd13: w = uc(MUL_LO,   ST_NONE, RES_SET_HI, 1'b0);
      5'd14: w = uc(MUL_HI,   ST_NONE, RES_NONE,   1'b0);
      5'd15: w = uc(MUL_NONE, ST_STEP, RES_NONE,   1'b0);
      5'd16: w = uc(MUL_NONE, ST_NONE, RES_SET_LO, 1'b1);
      5'd17: begin
        // skip the extra step when the top state bit is clear
        w         = uc(MUL_LO, ST_NONE, RES_ZERO, 1'b0);
        w.jmp_clr = 1'b1;
        w.target  = StirMain;
      end
      5'd18: w = uc(MUL_HI,   ST_NONE, RES_NONE,   1'b0);
      5'd19: w = uc(MUL_NONE, ST_STEP, RES_NONE,   1'b0);
      5'd20: w = uc(MUL_LO,   ST_NONE, RES_NONE,   1'b0);
      5'd21: w = uc(MUL_HI,   ST_NONE, RES_NONE,   1'b0);
      5'd22: w = uc(MUL_NONE, ST_STEP, RES_NONE,   1'b0);
      5'd23: w = uc(MUL_NONE, ST_STIR, RES_NONE,   1'b1);
      default: w = uc(MUL_NONE, ST_NONE, RES_ZERO, 1'b1);
    endcase
    return w;
  endfunction

endpackage

// ===== src/lcgf_datapath.sv =====
// Datapath: generator state, shared 32x32 multiplier, partial products and result word.
`timescale 1ns / 1ps
module lcgf_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lcgf_pkg::dp_ctrl_t ctrl_i,
  input  logic [31:0]       seed_i,
  input  logic [31:0]       rmax_i,
  output logic              top_bit_o,
  output logic [63:0]       res_next_o
);
  import lcgf_pkg::*;

  logic [63:0] state_q, state_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] prod_q, prod_d;
  logic [63:0] res_q;
  logic [31:0] mul_a, mul_b, hi, lo, rot;
  logic [63:0] mul_p;
  logic [1:0]  sel;

  assign hi  = state_q[63:32];
  assign lo  = state_q[31:0];
  assign sel = state_q[33:32];
  assign rot = {hi[26:0], hi[31:27]};

  always_comb begin
    mul_a = lo;
    mul_b = lcg_mult(sel);
    case (ctrl_i.mul)
      MUL_HI:  mul_a = hi;
      MUL_BND: begin
        mul_a = hi;
        mul_b = rmax_i;
      end
      default: mul_a = lo;
    endcase
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  always_comb begin
    acc_d  = acc_q;
    prod_d = prod_q;
    case (ctrl_i.mul)
      MUL_LO, MUL_BND: acc_d = mul_p;
      MUL_HI:          prod_d = mul_p[31:0];
      default:         acc_d = acc_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (ctrl_i.st)
      ST_STEP: state_d = acc_q + {prod_q, 32'd0} + {32'd0, lcg_add(sel)};
      ST_SEED: state_d = {32'd0, seed_i};
      ST_STIR: state_d = {hi, lo + (rot ^ seed_i)};
      default: state_d = state_q;
    endcase
  end

  always_comb begin
    res_next_o = res_q;
    case (ctrl_i.res)
      RES_ZERO:   res_next_o = '0;
      RES_SET_HI: res_next_o = {hi, res_q[31:0]};
      RES_SET_LO: res_next_o = {res_q[63:32], hi};
      RES_BND:    res_next_o = {res_q[63:32], acc_q[63:32]};
      default:    res_next_o = res_q;
    endcase
  end

  assign top_bit_o = state_q[63];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (ctrl_i.en) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      acc_q  <= acc_d;
      prod_q <= prod_d;
      res_q  <= res_next_o;
    end
  end

endmodule

// ===== src/lcg64_four_constant_rng.sv =====
// Top level: stream ports, microcode sequencer and output register of the four-constant LCG.
// Usage: one transaction on the s_axis side carries a mode in tuser and the seed and bound
// in tdata; each gives exactly one 64-bit transaction on the m_axis side.
// Items are worked one at a time by a microprogram stepping through a control store;
// s_axis_tready is high whenever no program runs, also while a result waits.
// The result is loaded into the output register when the last microstep of the program
// completes; stir runs an extra step when the top state bit is set.
// Each generator step takes three microsteps through the one 32x32 multiplier:
// low half product, high half product, then the 64-bit add of state.
// The next item is taken at the earliest in the cycle after the last microstep;
// no new item is taken while a program runs.
// Reset clears the state to zero, stops any program and drops m_axis_tvalid.
// A stalled receiver holds the result; a program that finishes meanwhile waits on
// its last microstep until the output register is free.
`timescale 1ns / 1ps
module lcg64_four_constant_rng (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] seed_value, [63:32] range_max
  input  logic [2:0]  s_axis_tuser,   // [2:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // [63:0] value
);
  import lcgf_pkg::*;

  logic           busy_q, busy_d;
  logic [PcW-1:0] pc_q, pc_d;
  logic [31:0]    seed_q, rmax_q;
  logic           out_valid_q, out_valid_d;
  logic [63:0]    out_q;
  logic [63:0]    res_next;
  logic           top_bit;
  logic           in_acc, out_free, adv, finish;
  ucode_t         cw;
  dp_ctrl_t       ctrl;

  assign cw            = ucode_rom(pc_q);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign adv           = busy_q && (!cw.last || out_free);
  assign finish        = adv && cw.last;
  assign s_axis_tready = !busy_q;

  assign ctrl.en  = adv;
  assign ctrl.mul = cw.mul;
  assign ctrl.st  = cw.st;
  assign ctrl.res = cw.res;

  always_comb begin
    busy_d      = busy_q;
    pc_d        = pc_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (finish) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
    end else if (adv) begin
      pc_d = (cw.jmp_clr && !top_bit) ? cw.target : pc_q + 1'b1;
    end
    if (in_acc) begin
      busy_d = 1'b1;
      pc_d   = mode_entry(s_axis_tuser);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      seed_q <= s_axis_tdata[31:0];
      rmax_q <= s_axis_tdata[63:32];
    end
    if (finish) begin
      out_q <= res_next;
    end
  end

  lcgf_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .seed_i     (seed_q),
    .rmax_i     (rmax_q),
    .top_bit_o  (top_bit),
    .res_next_o (res_next)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  a_finish_loads_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> m_axis_tvalid && !busy_q && (m_axis_tdata == $past(res_next)))
    else $error("finished program did not load the output register");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !finish)
    else $error("result overwritten while receiver stalls");

  a_seed_gives_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (cw.st == ST_SEED) |-> res_next == '0)
    else $error("seed program produced a non-zero value");

  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> busy_q && (pc_q == mode_entry($past(s_axis_tuser))))
    else $error("accepted item did not start its program");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the four-constant 64-bit LCG: stream driver, result monitor, predictor.
`timescale 1ns / 1ps
module tb_top;
  import lcgf_pkg::*;

  localparam logic [2:0] ModeSpareFirst = 3'd5;
  localparam logic [2:0] ModeSpareLast  = 3'd7;
  localparam int         HoldAt         = 1200;
  localparam int         HoldCycles     = 150;
  localparam int         QuietFrom      = 2000;
  localparam int         QuietTo        = 3500;
  localparam int         RandomReqs     = 700;
  localparam int         DrainAt        = 350;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] seed;
    logic [31:0] bound;
    bit          drain;
  } rng_req_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;   // [31:0] seed_value, [63:32] range_max
  logic [2:0]  s_axis_tuser  = '0;   // [2:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;         // [63:0] value

  rng_req_t    req_queue[$];
  logic [63:0] expected_draws[$];
  logic [63:0] rng_state = '0;
  int          n_accepted = 0;
  int          n_results  = 0;
  int          err_count  = 0;
  int          cyc        = 0;
  int          hold_left  = 0;
  int          mode_seen[8];
  int          stir_extra = 0;

  lcg64_four_constant_rng u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // one generator step; returns the new upper half
  function automatic logic [31:0] lcg_advance();
    logic [63:0] mult;
    logic [63:0] inc;
    case (rng_state[33:32])
      2'd0:    begin mult = 64'd1812433253; inc = 64'd123456789; end
      2'd1:    begin mult = 64'd2094358901; inc = 64'd239048723; end
      2'd2:    begin mult = 64'd1809384569; inc = 64'd958178125; end
      default: begin mult = 64'd1740025465; inc = 64'd281010345; end
    endcase
    rng_state = rng_state * mult + inc;
    return rng_state[63:32];
  endfunction

  function automatic logic [63:0] predict_draw(input logic [2:0] mode, input logic [31:0] seed,
                                               input logic [31:0] bound);
    logic [63:0] value;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] first;
    value = '0;
    mode_seen[mode]++;
    case (mode)
      MODE_SEED: rng_state = {32'd0, seed};
      MODE_STIR: begin
        if (rng_state[63]) begin
          void'(lcg_advance());
          stir_extra++;
        end
        hi = lcg_advance();
        lo = rng_state[31:0] + ({hi[26:0], hi[31:27]} ^ seed);
        rng_state = {hi, lo};
      end
      MODE_DRAW32: value = {32'd0, lcg_advance()};
      MODE_BOUNDED: value = ({32'd0, lcg_advance()} * {32'd0, bound}) >> 32;
      MODE_DRAW64: begin
        first = lcg_advance();
        value = {first, lcg_advance()};
      end
      default: ;
    endcase
    return value;
  endfunction

  function automatic void note_error(input string what, input logic [63:0] want,
                                     input logic [63:0] got);
    err_count++;
    if (err_count <= 10)
      $display("tb_top: %s at result %0d: expected %h, got %h", what, n_results, want, got);
  endfunction

  task automatic add_req(input logic [2:0] mode, input logic [31:0] seed,
                         input logic [31:0] bound, input bit drain);
    rng_req_t r;
    r.mode  = mode;
    r.seed  = seed;
    r.bound = bound;
    r.drain = drain;
    req_queue.push_back(r);
  endtask

  function automatic logic [31:0] pick_word();
    int unsigned r;
    r = $urandom_range(15);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'hFFFF_FFFF;
    if (r == 2) return 32'd1;
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_mode();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 7) return MODE_SEED;
    if (r < 22) return MODE_STIR;
    if (r < 45) return MODE_DRAW32;
    if (r < 70) return MODE_BOUNDED;
    if (r < 93) return MODE_DRAW64;
    return 3'($urandom_range(ModeSpareLast, ModeSpareFirst));
  endfunction

  function automatic bit quiet();
    return cyc >= QuietFrom && cyc < QuietTo;
  endfunction

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
  end

  // sender: prediction is made on the accepting edge
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    rng_req_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_draws.push_back(predict_draw(s_axis_tuser, s_axis_tdata[31:0],
                                              s_axis_tdata[63:32]));
        n_accepted <= n_accepted + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (req_queue.size() != 0 && (quiet() || $urandom_range(99) >= 14) &&
            !(req_queue[0].drain && (s_axis_tvalid || n_accepted != n_results))) begin
          nxt = req_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {nxt.bound, nxt.seed};
          s_axis_tuser  <= nxt.mode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver with random stalls and one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
    end else begin
      if (cyc == HoldAt) begin
        hold_left     <= HoldCycles;
        m_axis_tready <= 1'b0;
      end else begin
        if (hold_left > 0) hold_left <= hold_left - 1;
        m_axis_tready <= hold_left <= 1 && (quiet() || $urandom_range(99) >= 14);
      end
    end
  end

  always @(posedge clk_i) begin : monitor_proc
    logic [63:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results <= n_results + 1;
      if (expected_draws.size() == 0) begin
        note_error("unexpected transaction", '0, m_axis_tdata);
      end else begin
        want = expected_draws.pop_front();
        if (m_axis_tdata !== want) note_error("value mismatch", want, m_axis_tdata);
      end
    end
  end

  initial begin
    // directed: reset state, field extremes, every mode, spare modes
    add_req(MODE_DRAW32,     32'd0,         32'd0,         1'b0);
    add_req(MODE_STIR,       32'd0,         32'd0,         1'b0);
    add_req(MODE_SEED,       32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_req(MODE_DRAW32,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_req(MODE_BOUNDED,    32'd0,         32'd0,         1'b0);
    add_req(MODE_BOUNDED,    32'd0,         32'hFFFF_FFFF, 1'b0);
    add_req(MODE_BOUNDED,    32'd0,         32'd1,         1'b0);
    add_req(MODE_DRAW64,     32'd0,         32'd0,         1'b0);
    add_req(MODE_STIR,       32'hFFFF_FFFF, 32'd0,         1'b0);
    add_req(MODE_DRAW64,     32'd0,         32'd0,         1'b0);
    add_req(MODE_STIR,       32'hA5A5_5A5A, 32'd0,         1'b0);
    add_req(MODE_STIR,       32'h8000_0001, 32'd0,         1'b0);
    add_req(MODE_SEED,       32'd0,         32'd0,         1'b0);
    add_req(MODE_DRAW32,     32'd0,         32'd0,         1'b0);
    add_req(ModeSpareFirst,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_req(3'd6,            32'h1234_5678, 32'h8765_4321, 1'b0);
    add_req(ModeSpareLast,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_req(MODE_DRAW32,     32'd0,         32'd0,         1'b0);
    add_req(MODE_STIR,       32'd0,         32'd0,         1'b0);
    add_req(MODE_DRAW64,     32'hFFFF_FFFF, 32'd0,         1'b0);
    for (int i = 0; i < RandomReqs; i++)
      add_req(pick_mode(), pick_word(), pick_word(), i == 0 || i == DrainAt);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (req_queue.size() != 0 || s_axis_tvalid || n_accepted != n_results);
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
    if (expected_draws.size() != 0) begin
      $display("tb_top: %0d results never arrived", expected_draws.size());
      err_count += expected_draws.size();
    end

    $display("tb_top: %0d transactions checked; seed %0d, stir %0d (%0d with extra step),",
             n_results, mode_seen[MODE_SEED], mode_seen[MODE_STIR], stir_extra);
    $display("tb_top: draw32 %0d, bounded %0d, draw64 %0d, spare modes %0d, %0d mismatches",
             mode_seen[MODE_DRAW32], mode_seen[MODE_BOUNDED], mode_seen[MODE_DRAW64],
             mode_seen[5] + mode_seen[6] + mode_seen[7], err_count);
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/lcgf_pkg.sv
src/lcgf_datapath.sv
src/lcg64_four_constant_rng.sv
bench/tb_top.sv
